>>> rtl/pch_pkg.sv
// Shared constants and controller/datapath interface types of the printable
// character histogram. No dependencies.
package pch_pkg;

    localparam int NUM_BINS        = 95;
    localparam int BIN_IDX_W       = 7;
    localparam int COUNT_WIDTH_DEF = 16;
    localparam int CHAR_W          = 7;
    localparam int OCC_W           = 16;
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_IDX_W       = 2;
    localparam int MASK_LOW_W      = 64;
    localparam int MASK_HIGH_W     = 31;

    localparam logic [7:0]           FIRST_CODE = 8'd32;
    localparam logic [7:0]           LAST_CODE  = 8'd126;
    localparam logic [OCC_W-1:0]     OCC_MAX    = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_EN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK_LOW    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK_HIGH   = 2'd2;

    localparam logic KIND_DATA  = 1'b0;
    localparam logic KIND_FETCH = 1'b1;

    typedef struct packed {
        logic rd_count;
        logic inc_write;
        logic rd_scan;
        logic cursor_step;
        logic load_hit;
        logic load_end;
    } pch_cmd_t;

    typedef struct packed {
        logic byte_ok;
        logic cursor_end;
        logic cursor_hit;
        logic out_free;
    } pch_stat_t;

endpackage

>>> rtl/printable_char_histogram_top.sv
// Printable character histogram: a byte stream is counted into 95 saturating
// bins (codes 32 to 126) with an optional filter mask; a fetch word returns
// the next nonzero bin from a scan cursor, and an exhausted fetch returns
// found = 0, clears every bin and rewinds the cursor. Bins are flagged by
// valid bits cleared at reset and by the exhausted fetch, so no clearing pass
// is needed. One word is taken at a time. A counted data byte reads its bin
// and then writes it back; a byte that is not counted is dropped while idle.
// A fetch steps the cursor over empty bins, reads a hit bin, and waits for
// the output register to drain before loading the result. Output words sit
// in a register, so a loaded result does not block data bytes, but a later
// fetch waits for it to drain. Depends on pch_pkg, pch_ctrl, pch_datapath.
module printable_char_histogram_top #(
    parameter int COUNT_WIDTH = pch_pkg::COUNT_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [pch_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pch_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,   // [7:0] data_byte
    input  logic                               s_tuser,   // [0] kind
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [23:0]                        m_tdata,   // [6:0] character, [22:7] occurrences
    output logic                               m_tuser    // [0] found
);
    import pch_pkg::*;

    pch_cmd_t  cmd;
    pch_stat_t stat;

    pch_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .kind     (s_tuser),
        .stat     (stat),
        .cmd      (cmd)
    );

    pch_datapath #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .data_byte (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

>>> rtl/pch_datapath.sv
// Datapath of the printable character histogram: configuration registers,
// bin memory with valid bits, scan cursor and output word register.
// Depends on pch_pkg.
module pch_datapath #(
    parameter int COUNT_WIDTH = pch_pkg::COUNT_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [pch_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pch_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [7:0]                         data_byte,
    input  pch_pkg::pch_cmd_t                  cmd,
    output pch_pkg::pch_stat_t                 stat,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [23:0]                        m_tdata,
    output logic                               m_tuser
);
    import pch_pkg::*;

    logic                         filter_en_reg;
    logic [MASK_LOW_W-1:0]        mask_low_reg;
    logic [MASK_HIGH_W-1:0]       mask_high_reg;
    logic [NUM_BINS-1:0]          filter_mask;

    logic [COUNT_WIDTH-1:0]       mem [NUM_BINS];
    logic [COUNT_WIDTH-1:0]       rdata_reg;
    logic [NUM_BINS-1:0]          valid_reg;
    logic [NUM_BINS-1:0]          valid_next;
    logic [BIN_IDX_W-1:0]         idx_reg;
    logic [BIN_IDX_W-1:0]         cursor_reg;
    logic [BIN_IDX_W-1:0]         cursor_next;

    logic [BIN_IDX_W-1:0]         byte_idx;
    logic [BIN_IDX_W-1:0]         rd_addr;
    logic                         rd_en;
    logic [COUNT_WIDTH-1:0]       count_eff;
    logic                         count_full;
    logic                         mem_we;

    logic [31:0]                  cnt32;
    logic [OCC_W-1:0]             occ_sat;

    logic                         out_valid_reg;
    logic                         found_reg;
    logic [CHAR_W-1:0]            char_reg;
    logic [OCC_W-1:0]             occ_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_en_reg <= 1'b0;
            mask_low_reg  <= '0;
            mask_high_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FILTER_EN: filter_en_reg <= cfg_data[0];
                CFG_MASK_LOW:  mask_low_reg  <= cfg_data[MASK_LOW_W-1:0];
                CFG_MASK_HIGH: mask_high_reg <= cfg_data[MASK_HIGH_W-1:0];
                default:       ;
            endcase
        end
    end

    assign filter_mask = {mask_high_reg, mask_low_reg};
    assign byte_idx    = data_byte[BIN_IDX_W-1:0] - BIN_IDX_W'(FIRST_CODE);

    always_comb
    begin
        stat.byte_ok    = (data_byte >= FIRST_CODE) && (data_byte <= LAST_CODE)
                          && (!filter_en_reg || filter_mask[byte_idx]);
        stat.cursor_end = (cursor_reg == BIN_IDX_W'(NUM_BINS));
        stat.cursor_hit = !stat.cursor_end && valid_reg[cursor_reg];
        stat.out_free   = !out_valid_reg || m_tready;
    end

    assign rd_en      = cmd.rd_count || cmd.rd_scan;
    assign rd_addr    = cmd.rd_scan ? cursor_reg : byte_idx;
    assign count_eff  = valid_reg[idx_reg] ? rdata_reg : '0;
    assign count_full = (count_eff == '1);
    assign mem_we     = cmd.inc_write && !count_full;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[idx_reg] <= count_eff + COUNT_WIDTH'(1);
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
        if (cmd.rd_count)
        begin
            idx_reg <= byte_idx;
        end
    end

    always_comb
    begin
        valid_next  = valid_reg;
        cursor_next = cursor_reg;
        if (mem_we)
        begin
            valid_next[idx_reg] = 1'b1;
        end
        if (cmd.cursor_step || cmd.load_hit)
        begin
            cursor_next = cursor_reg + BIN_IDX_W'(1);
        end
        if (cmd.load_end)
        begin
            valid_next  = '0;
            cursor_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            cursor_reg <= '0;
        end
        else
        begin
            valid_reg  <= valid_next;
            cursor_reg <= cursor_next;
        end
    end

    assign cnt32   = 32'(rdata_reg);
    assign occ_sat = (cnt32 > 32'(OCC_MAX)) ? OCC_MAX : cnt32[OCC_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_hit || cmd.load_end)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_hit)
        begin
            found_reg <= 1'b1;
            char_reg  <= cursor_reg + CHAR_W'(FIRST_CODE);
            occ_reg   <= occ_sat;
        end
        else if (cmd.load_end)
        begin
            found_reg <= 1'b0;
            char_reg  <= '0;
            occ_reg   <= '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = found_reg;
    assign m_tdata  = {1'b0, occ_reg, char_reg};

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_end |=> (valid_reg == '0) && (cursor_reg == '0))
        else $error("exhausted fetch did not clear bins and cursor");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_reg <= BIN_IDX_W'(NUM_BINS))
        else $error("scan cursor beyond last bin");

    a_inc_marks: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.inc_write |=> valid_reg[$past(idx_reg)])
        else $error("counted bin not marked nonzero");

    a_hit_found: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_hit |=> m_tvalid && m_tuser)
        else $error("hit result not presented as found");

endmodule

>>> rtl/pch_ctrl.sv
// Controller state machine of the printable character histogram: sequences
// counting, scanning and result hand-off. Depends on pch_pkg.
module pch_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                kind,
    input  pch_pkg::pch_stat_t  stat,
    output pch_pkg::pch_cmd_t   cmd
);
    import pch_pkg::*;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_INC      = 3'd1;
    localparam logic [2:0] ST_SCAN     = 3'd2;
    localparam logic [2:0] ST_EMIT_HIT = 3'd3;
    localparam logic [2:0] ST_EMIT_END = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (kind == KIND_FETCH)
                    begin
                        state_next = ST_SCAN;
                    end
                    else if (stat.byte_ok)
                    begin
                        cmd.rd_count = 1'b1;
                        state_next   = ST_INC;
                    end
                end
            end
            ST_INC:
            begin
                cmd.inc_write = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_SCAN:
            begin
                priority if (stat.cursor_end)
                begin
                    state_next = ST_EMIT_END;
                end
                else if (stat.cursor_hit)
                begin
                    cmd.rd_scan = 1'b1;
                    state_next  = ST_EMIT_HIT;
                end
                else
                begin
                    cmd.cursor_step = 1'b1;
                end
            end
            ST_EMIT_HIT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_hit = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_EMIT_END:
            begin
                if (stat.out_free)
                begin
                    cmd.load_end = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
